[hw/rtl/assert_macros.svh]
// Assertion macros for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check an implication on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Check an implication on the next cycle, outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

[hw/rtl/optt_pkg.sv]
// Types and constants of the obstacle point trace table.
package optt_pkg;
    localparam logic [1:0] OUT_MERGED   = 2'd0;
    localparam logic [1:0] OUT_ADDED    = 2'd1;
    localparam logic [1:0] OUT_REPLACED = 2'd2;
    localparam logic [1:0] OUT_PRUNED   = 2'd3;
    localparam logic [0:0] ACT_APPEND   = 1'b0;
    localparam logic [0:0] ACT_PRUNE    = 1'b1;
    localparam logic [1:0] REG_SPACING  = 2'd0;
    localparam logic [1:0] REG_TTL      = 2'd1;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [31:0]        seen;
        logic [7:0]         hits;
    } t_point;

    typedef enum logic [2:0] {
        ST_IDLE, ST_SCAN, ST_WAIT, ST_WRITE, ST_DONE
    } t_state;
endpackage

[hw/rtl/optt_mem.sv]
// Point table memory: one write port, one registered read port.
module optt_mem
    import optt_pkg::*;
#(
    parameter int AW = 6
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_point        i_wdata,
    input  logic [AW-1:0] i_raddr,
    output t_point        o_rdata
);
    t_point r_mem [2**AW];
    t_point r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end
    assign o_rdata = r_rdata;
endmodule

[hw/rtl/optt_dist.sv]
// Registered squared-distance unit: two 17x17 squares then a sum.
module optt_dist
    import optt_pkg::*;
(
    input  logic               i_clk,
    input  logic signed [15:0] i_ax,
    input  logic signed [15:0] i_ay,
    input  logic signed [15:0] i_bx,
    input  logic signed [15:0] i_by,
    output logic [32:0]        o_dist
);
    logic signed [16:0] dx, dy;
    logic [33:0] r_sx, r_sy;
    logic [34:0] sum;

    assign dx = 17'(i_ax) - 17'(i_bx);
    assign dy = 17'(i_ay) - 17'(i_by);
    always_ff @(posedge i_clk) begin
        r_sx <= 34'(dx * dx);
        r_sy <= 34'(dy * dy);
    end
    assign sum = 35'(r_sx) + 35'(r_sy);
    assign o_dist = sum[32:0];
endmodule

[hw/rtl/obstacle_point_trace_table.sv]
// Obstacle point trace table: one result per append or prune item.
// Input word (s_axis): action, pos_x, pos_y, stamp_ms. Result word (m_axis):
// outcome, entry_index, entry_count, removed_count.
// Each item walks the valid entries once through the table memory, one
// entry per cycle; the walk drains through the registered memory read and
// the distance register. A merge, add or replace writes one entry at the end.
// Prune compacts in place during the walk (write index never passes read).
// One item is processed at a time; s_axis_tready is low while busy and
// while a result waits. The result is held in a register until taken, so
// a stalled receiver just holds the block. Reset empties the table (count
// zero) and loads the register defaults; memory contents are not cleared.
// APB: register 0 match_spacing at 0x0, register 1 time_to_live at 0x4.
`include "assert_macros.svh"
module obstacle_point_trace_table
    import optt_pkg::*;
#(
    parameter int TABLE_DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata, // pos_x, pos_y, stamp_ms
    input  logic        s_axis_tuser, // action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata, // outcome, entry_index, entry_count, removed_count
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    t_state r_state, n_state;
    logic [15:0] r_spacing;
    logic [31:0] r_ttl;
    logic [CW-1:0] r_count;
    logic r_act;
    logic signed [15:0] r_px, r_py;
    logic [31:0] r_now;
    logic [CW-1:0] r_rd;      // read index issued
    logic [CW-1:0] r_wr;      // prune write index
    logic r_v1, r_v2;         // pipeline valids
    logic [CW-1:0] r_i1;
    t_point r_p2;
    logic [CW-1:0] r_i2;
    logic r_found;
    logic [32:0] r_best;
    logic [AW-1:0] r_slot;
    t_point r_slot_pt;
    logic [31:0] r_oldest_age;
    logic [AW-1:0] r_oldest;
    logic [23:0] r_out;
    logic r_ovalid;

    t_point rdata, wdata;
    logic we;
    logic [AW-1:0] waddr;
    logic [32:0] sq_dist, limit;
    logic [31:0] lim_prod;
    logic [31:0] age2;
    logic accept_in;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_TTL[0]) ? r_ttl : {16'd0, r_spacing};
    assign lim_prod = 32'(r_spacing) * 32'(r_spacing);
    assign limit = {1'b0, lim_prod};

    optt_mem #(.AW(AW)) u_mem (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(r_rd[AW-1:0]), .o_rdata(rdata)
    );
    optt_dist u_dist (
        .i_clk(i_clk), .i_ax(rdata.x), .i_ay(rdata.y), .i_bx(r_px), .i_by(r_py),
        .o_dist(sq_dist)
    );

    assign accept_in = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE) && !r_ovalid;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata = r_out;
    assign age2 = r_now - r_p2.seen;

    function automatic logic signed [15:0] smooth(logic signed [15:0] o,
                                                  logic signed [15:0] n);
        logic signed [25:0] s;
        s = 26'(o) * 26'sd174 + 26'(n) * 26'sd82;
        return s[23:8];
    endfunction

    // Write port: prune compaction in the scan and wait states, final update at write.
    always_comb begin
        we = 1'b0;
        waddr = r_wr[AW-1:0];
        wdata = r_p2;
        if (r_state == ST_WRITE) begin
            we = 1'b1;
            if (r_found) begin
                waddr = r_slot;
                wdata.x = smooth(r_slot_pt.x, r_px);
                wdata.y = smooth(r_slot_pt.y, r_py);
                wdata.seen = r_now;
                wdata.hits = (r_slot_pt.hits == 8'hFF) ? 8'hFF : r_slot_pt.hits + 8'd1;
            end else begin
                waddr = (r_count == CW'(TABLE_DEPTH)) ? r_oldest : r_count[AW-1:0];
                wdata.x = r_px;
                wdata.y = r_py;
                wdata.seen = r_now;
                wdata.hits = 8'd1;
            end
        end else if (r_v2 && r_act == ACT_PRUNE && !(age2 > r_ttl)) begin
            we = 1'b1;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (accept_in) n_state = ST_SCAN;
            ST_SCAN:  if (r_rd >= r_count) n_state = ST_WAIT;
            ST_WAIT:  if (!r_v1 && !r_v2) n_state = (r_act == ACT_PRUNE) ? ST_DONE : ST_WRITE;
            ST_WRITE: n_state = ST_DONE;
            ST_DONE:  n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_spacing <= 16'd100;
            r_ttl <= 32'd2000;
            r_count <= '0;
            r_ovalid <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_state <= n_state;
            if (psel && penable && pwrite) begin
                if (paddr[2] == REG_SPACING[0]) r_spacing <= pwdata[15:0];
                else r_ttl <= pwdata;
            end
            if (m_axis_tvalid && m_axis_tready) r_ovalid <= 1'b0;
            // read pipeline: r_v1 = memory data valid, r_v2 = distance valid
            r_v1 <= (r_state == ST_SCAN) && (r_rd < r_count);
            r_v2 <= r_v1;
            if (r_state == ST_WRITE && !r_found && r_count != CW'(TABLE_DEPTH))
                r_count <= r_count + CW'(1);
            if (r_state == ST_DONE) begin
                r_ovalid <= 1'b1;
                if (r_act == ACT_PRUNE) r_count <= r_wr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept_in) begin
            r_act <= s_axis_tuser;
            r_px <= s_axis_tdata[15:0];
            r_py <= s_axis_tdata[31:16];
            r_now <= s_axis_tdata[63:32];
            r_rd <= '0;
            r_wr <= '0;
            r_found <= 1'b0;
            r_oldest_age <= '0;
            r_oldest <= '0;
        end
        if (r_state == ST_SCAN && r_rd < r_count) r_rd <= r_rd + CW'(1);
        r_i1 <= r_rd;
        r_p2 <= rdata;
        r_i2 <= r_i1;
        if (r_v2) begin
            if (r_act == ACT_PRUNE) begin
                if (!(age2 > r_ttl)) r_wr <= r_wr + CW'(1);
            end else begin
                if (sq_dist <= limit && (!r_found || sq_dist < r_best)) begin
                    r_found <= 1'b1;
                    r_best <= sq_dist;
                    r_slot <= r_i2[AW-1:0];
                    r_slot_pt <= r_p2;
                end
                if (r_i2 == '0 || age2 > r_oldest_age) begin
                    r_oldest_age <= age2;
                    r_oldest <= r_i2[AW-1:0];
                end
            end
        end
        if (r_state == ST_WRITE) begin
            r_out[1:0] <= r_found ? OUT_MERGED
                        : (r_count == CW'(TABLE_DEPTH)) ? OUT_REPLACED : OUT_ADDED;
            r_out[7:2] <= 6'(waddr);
            r_out[23:15] <= '0;
        end
        if (r_state == ST_DONE) begin
            if (r_act == ACT_PRUNE) begin
                r_out[1:0] <= OUT_PRUNED;
                r_out[7:2] <= '0;
                r_out[14:8] <= 7'(r_wr);
                r_out[21:15] <= 7'(r_count - r_wr);
                r_out[23:22] <= '0;
            end else begin
                r_out[14:8] <= 7'(r_count);
            end
        end
    end

    `ASSERT_IMPL(a_no_accept_busy, i_clk, i_rst_n, r_state != ST_IDLE, !s_axis_tready)
    `ASSERT_IMPL(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(TABLE_DEPTH))
    `ASSERT_NEXT(a_done_valid, i_clk, i_rst_n, r_state == ST_DONE, m_axis_tvalid)
    `ASSERT_IMPL(a_wr_behind, i_clk, i_rst_n, r_state == ST_SCAN, r_wr <= r_rd)
endmodule

[sim/optt_checker.sv]
// Checker for the obstacle point trace table: predicts each result and compares.
`timescale 1ns / 1ps
module optt_checker
    import optt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata, // pos_x, pos_y, stamp_ms
    input  logic        s_axis_tuser, // action
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [23:0] m_axis_tdata, // outcome, entry_index, entry_count, removed_count
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_results,
    output int          o_merges,
    output int          o_replaces,
    output int          o_removed
);
    localparam int DEPTH = 64;

    typedef struct packed {
        logic [6:0] removed;
        logic [6:0] count;
        logic [5:0] index;
        logic [1:0] outcome;
    } t_result;

    t_point     table_mirror[DEPTH];
    int         live_count;
    logic [15:0] spacing;
    logic [31:0] ttl;
    t_result    expected_results[$];

    function automatic logic signed [15:0] blend(logic signed [15:0] old_v,
                                                 logic signed [15:0] new_v);
        logic signed [31:0] s;
        s = old_v * 32'sd174 + new_v * 32'sd82;
        return 16'(s >>> 8);
    endfunction

    function automatic t_result predict_item(logic act, logic signed [15:0] px,
                                             logic signed [15:0] py, logic [31:0] now);
        t_result r;
        logic [63:0] lim, best, d;
        logic signed [63:0] dx, dy;
        logic [31:0] age, oldest;
        bit found;
        int wr, slot;
        r = '0;
        slot = 0;
        found = 0;
        best = 0;
        if (act == ACT_PRUNE) begin
            wr = 0;
            for (int i = 0; i < live_count; i++) begin
                age = now - table_mirror[i].seen;
                if (age > ttl) continue;
                table_mirror[wr] = table_mirror[i];
                wr++;
            end
            r.removed = 7'(live_count - wr);
            live_count = wr;
            r.outcome = OUT_PRUNED;
        end else begin
            lim = 64'(spacing) * 64'(spacing);
            for (int i = 0; i < live_count; i++) begin
                dx = 64'(table_mirror[i].x) - 64'(px);
                dy = 64'(table_mirror[i].y) - 64'(py);
                d = dx * dx + dy * dy;
                if (d <= lim && (!found || d < best)) begin
                    best = d;
                    slot = i;
                    found = 1;
                end
            end
            if (found) begin
                table_mirror[slot].x = blend(table_mirror[slot].x, px);
                table_mirror[slot].y = blend(table_mirror[slot].y, py);
                table_mirror[slot].seen = now;
                if (table_mirror[slot].hits != 8'd255)
                    table_mirror[slot].hits++;
                r.outcome = OUT_MERGED;
            end else begin
                if (live_count >= DEPTH) begin
                    oldest = now - table_mirror[0].seen;
                    for (int i = 1; i < live_count; i++) begin
                        age = now - table_mirror[i].seen;
                        if (age > oldest) begin
                            oldest = age;
                            slot = i;
                        end
                    end
                    r.outcome = OUT_REPLACED;
                end else begin
                    slot = live_count;
                    live_count++;
                    r.outcome = OUT_ADDED;
                end
                table_mirror[slot] = '{x: px, y: py, seen: now, hits: 8'd1};
            end
            r.index = 6'(slot);
        end
        r.count = 7'(live_count);
        return r;
    endfunction

    assign o_pending = expected_results.size();

    always @(posedge i_clk) begin
        t_result want, got;
        if (!i_rst_n) begin
            live_count = 0;
            spacing <= 16'd100;
            ttl <= 32'd2000;
            expected_results.delete();
            o_fail_count <= 0;
            o_results <= 0;
            o_merges <= 0;
            o_replaces <= 0;
            o_removed <= 0;
        end else begin
            if (psel && penable && pwrite) begin
                if (paddr[2:2] == 1'(REG_SPACING)) spacing <= pwdata[15:0];
                else ttl <= pwdata;
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_results.push_back(predict_item(s_axis_tuser,
                    s_axis_tdata[15:0], s_axis_tdata[31:16], s_axis_tdata[63:32]));
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[21:0];
                o_results <= o_results + 1;
                if (expected_results.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("unexpected result word %h", m_axis_tdata);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (want.outcome == OUT_MERGED) o_merges <= o_merges + 1;
                    if (want.outcome == OUT_REPLACED) o_replaces <= o_replaces + 1;
                    o_removed <= o_removed + want.removed;
                    if (got !== want || m_axis_tdata[23:22] !== 2'd0) begin
                        if (o_fail_count < 10)
                            $display("mismatch: outcome %0d/%0d index %0d/%0d count %0d/%0d removed %0d/%0d (exp/act)",
                                want.outcome, got.outcome, want.index, got.index,
                                want.count, got.count, want.removed, got.removed);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

[sim/tb.sv]
// Testbench top: drives items and register writes, gives the verdict.
`timescale 1ns / 1ps
module tb
    import optt_pkg::*;
();

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0; // pos_x, pos_y, stamp_ms
    logic        s_axis_tuser = 0;  // action
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [23:0] m_axis_tdata;      // outcome, entry_index, entry_count, removed_count
    logic        psel = 0, penable = 0, pwrite = 0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int fail_count, pending, results, merges, replaces, removed;
    int cycles = 0;
    logic [31:0] clock_ms = 0;
    int base_x, base_y;

    always #6 i_clk = ~i_clk;

    obstacle_point_trace_table u_top (.*);

    optt_checker u_chk (.*, .o_fail_count(fail_count), .o_pending(pending),
        .o_results(results), .o_merges(merges), .o_replaces(replaces), .o_removed(removed));

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 90);
    endfunction

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 1500000) begin
            $display("tb: errors");
            $finish;
        end
    end

    // Receiver: random stalls, with calm stretches.
    initial begin
        int hold;
        forever begin
            @(posedge i_clk);
            if ((cycles / 4000) % 3 == 2) m_axis_tready <= 1;
            else begin
                hold = gap_len();
                m_axis_tready <= (hold == 0);
            end
        end
    end

    task automatic reg_write(logic [1:0] idx, logic [31:0] val);
        psel <= 1; pwrite <= 1; paddr <= {idx[0], 2'b00}; pwdata <= val;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        @(posedge i_clk);
    endtask

    // Hold valid across back-to-back words; drop it only before a gap.
    task automatic send(logic act, logic signed [15:0] px, logic signed [15:0] py,
                        logic [31:0] now);
        int g;
        g = ((cycles / 4000) % 3 == 1) ? 0 : gap_len();
        if (g > 0) begin
            s_axis_tvalid <= 0;
            repeat (g) @(posedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tuser <= act;
        s_axis_tdata <= {now, py, px};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic drain();
        s_axis_tvalid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic random_phase(int n, int spread);
        logic [31:0] r;
        for (int k = 0; k < n; k++) begin
            r = $urandom;
            clock_ms = clock_ms + $urandom_range(0, (r[3:0] == 0) ? 3000 : 40);
            if (r[7:4] == 0)
                send(ACT_PRUNE, 16'($urandom), 16'($urandom), clock_ms);
            else if (r[9:8] == 0)
                send(ACT_APPEND, 16'($urandom), 16'($urandom), clock_ms);
            else
                send(ACT_APPEND, 16'(base_x + $signed($urandom_range(0, 2 * spread)) - spread),
                     16'(base_y + $signed($urandom_range(0, 2 * spread)) - spread), clock_ms);
            if (r[15:10] == 0) begin
                base_x = $signed(16'($urandom));
                base_y = $signed(16'($urandom));
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        // Directed: empty prune, extremes, exact-spacing match, repeated merges, full table.
        send(ACT_PRUNE, 0, 0, 0);
        send(ACT_APPEND, 16'sh8000, 16'sh8000, 0);
        send(ACT_APPEND, 16'sh7fff, 16'sh7fff, 32'd5);
        send(ACT_APPEND, 16'sh7fff - 16'sd100, 16'sh7fff, 32'd6);
        send(ACT_APPEND, 16'sh7fff - 16'sd50, 16'sh7fff, 32'd7);
        send(ACT_APPEND, 16'sh8000 + 16'sd60, 16'sh8000 + 16'sd80, 32'd8);
        for (int k = 0; k < 8; k++) send(ACT_APPEND, 16'sd1000, -16'sd1000, 32'd10 + k);
        send(ACT_PRUNE, 0, 0, 32'd2007);
        send(ACT_PRUNE, 0, 0, 32'd2008);
        send(ACT_PRUNE, 0, 0, 32'hffff_ffff);
        drain();
        reg_write(REG_SPACING, 32'd0);
        reg_write(REG_TTL, 32'hffff_ffff);
        for (int k = 0; k < 66; k++) send(ACT_APPEND, 16'(k * 7), -16'(k * 3), 32'd100 + k % 5);
        send(ACT_APPEND, 16'sd0, 16'sd0, 32'd200);
        send(ACT_PRUNE, 0, 0, 32'd50);
        drain();
        // Merge-heavy long run with full table, then prunes with a tight ttl.
        clock_ms = 32'hffff_f000;
        base_x = 0; base_y = 0;
        reg_write(REG_SPACING, 32'd300);
        reg_write(REG_TTL, 32'd2000);
        random_phase(300, 400);
        drain();
        reg_write(REG_SPACING, 32'hffff);
        reg_write(REG_TTL, 32'd0);
        random_phase(150, 20000);
        drain();
        reg_write(REG_SPACING, 32'd20);
        reg_write(REG_TTL, 32'd500);
        random_phase(330, 60);
        drain();
        $display("covered %0d results: %0d merges, %0d replacements, %0d pruned entries",
                 results, merges, replaces, removed);
        if (fail_count == 0) $display("tb: clean");
        else $display("tb: errors");
        $finish;
    end
endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/optt_pkg.sv
hw/rtl/optt_mem.sv
hw/rtl/optt_dist.sv
hw/rtl/obstacle_point_trace_table.sv
sim/optt_checker.sv
sim/tb.sv
